@@ src/mme_pkg.sv @@
// Shared types, constants and helpers of the matrix multiply engine.
// Used by mme_ctrl, mme_dp and matrix_multiply_engine_core; depends on nothing.
`default_nettype none

package mme_pkg;

    // Largest matrix dimension and the widths that follow from it.
    localparam int DIM      = 8;
    localparam int IDX_W    = $clog2(DIM);
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = DIM * DIM;
    localparam int DIM_W    = 4;

    // Element and arithmetic widths.
    localparam int ELEM_W   = 16;
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int SUM_W    = 35;

    // Stream payload widths.
    localparam int OP_W       = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 48;
    localparam int CFG_ADDR_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROWS_M  = 2'd0,
        REG_INNER_K = 2'd1,
        REG_COLS_N  = 2'd2,
        REG_NONE    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_WAIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic              issue;
        logic              first;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic              load_out;
        logic [IDX_W-1:0]  out_row;
        logic [IDX_W-1:0]  out_col;
        logic              out_last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

    // Last valid index for a dimension register: zero acts as one, values
    // above the maximum act as the maximum.
    function automatic logic [IDX_W-1:0] last_index(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        begin
            if (v == '0) begin
                d = DIM_W'(1);
            end else if (v > DIM_W'(DIM)) begin
                d = DIM_W'(DIM);
            end else begin
                d = v;
            end
            last_index = IDX_W'(d - DIM_W'(1));
        end
    endfunction

endpackage

`default_nettype wire

@@ src/mme_ctrl.sv @@
// Controller of the matrix multiply engine: dimension registers, loop
// counters and the sequencing state machine. Depends on mme_pkg.
`default_nettype none

module mme_ctrl
    import mme_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [DIM_W-1:0]      cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [OP_W-1:0]       s_tuser,
    input  wire dp_status_t            status,
    output dp_cmd_t                    cmd
);

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] rows_m_reg, inner_k_reg, cols_n_reg;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] l_reg, l_next;
    logic [IDX_W-1:0] m_last, k_last, n_last;
    logic             accept;
    logic             emit;
    opcode_t          op;

    assign op     = opcode_t'(s_tuser);
    assign m_last = last_index(rows_m_reg);
    assign k_last = last_index(inner_k_reg);
    assign n_last = last_index(cols_n_reg);
    assign accept = s_tvalid && s_tready;
    assign emit   = (state_reg == ST_WAIT) && !status.pipe_busy && status.out_free;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_m_reg  <= DIM_W'(DIM);
            inner_k_reg <= DIM_W'(DIM);
            cols_n_reg  <= DIM_W'(DIM);
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_addr))
                REG_ROWS_M:  rows_m_reg  <= cfg_wdata;
                REG_INNER_K: inner_k_reg <= cfg_wdata;
                REG_COLS_N:  cols_n_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            l_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            l_reg     <= l_next;
        end
    end

    // Next state and loop counters.
    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        l_next     = l_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && op == OP_COMPUTE) begin
                    state_next = ST_MAC;
                    i_next     = '0;
                    j_next     = '0;
                    l_next     = '0;
                end
            end
            ST_MAC: begin
                if (l_reg == k_last) begin
                    l_next     = '0;
                    state_next = ST_WAIT;
                end else begin
                    l_next = l_reg + IDX_W'(1);
                end
            end
            ST_WAIT: begin
                if (emit) begin
                    if (j_reg == n_last) begin
                        j_next = '0;
                        if (i_reg == m_last) begin
                            i_next     = '0;
                            state_next = ST_IDLE;
                        end else begin
                            i_next     = i_reg + IDX_W'(1);
                            state_next = ST_MAC;
                        end
                    end else begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = ST_MAC;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        cmd          = '0;
        cmd.addr_a   = {i_reg, l_reg};
        cmd.addr_b   = {l_reg, j_reg};
        cmd.first    = (l_reg == '0);
        cmd.out_row  = i_reg;
        cmd.out_col  = j_reg;
        cmd.out_last = (i_reg == m_last) && (j_reg == n_last);
        unique case (state_reg)
            ST_IDLE: begin
                cmd.wr_a = accept && (op == OP_WRITE_A);
                cmd.wr_b = accept && (op == OP_WRITE_B);
            end
            ST_MAC:  cmd.issue    = 1'b1;
            ST_WAIT: cmd.load_out = emit;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

@@ src/mme_dp.sv @@
// Datapath of the matrix multiply engine: the two element stores, the
// multiply-accumulate pipeline and the result register. Depends on mme_pkg.
`default_nettype none

module mme_dp
    import mme_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire dp_cmd_t              cmd,
    output dp_status_t                status,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    logic [ELEM_W-1:0]        mem_a [DEPTH];
    logic [ELEM_W-1:0]        mem_b [DEPTH];
    logic [ADDR_W-1:0]        wr_addr;
    logic [ELEM_W-1:0]        wr_value;

    logic signed [ELEM_W-1:0] a_rd_reg, b_rd_reg;
    logic                     rd_vld_reg, rd_first_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg, prod_first_reg;
    logic signed [SUM_W-1:0]  acc_reg, acc_next;

    logic                     out_vld_reg;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic [SUM_W-1:0]         out_sum_reg;
    logic                     out_last_reg;

    // Write address is row then column, matching the read addressing.
    assign wr_addr  = {s_tdata[0 +: IDX_W], s_tdata[IDX_W +: IDX_W]};
    assign wr_value = s_tdata[2*IDX_W +: ELEM_W];

    always_ff @(posedge aclk) begin
        if (cmd.wr_a) begin
            mem_a[wr_addr] <= wr_value;
        end
        if (cmd.wr_b) begin
            mem_b[wr_addr] <= wr_value;
        end
        if (cmd.issue) begin
            a_rd_reg <= mem_a[cmd.addr_a];
            b_rd_reg <= mem_b[cmd.addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= cmd.issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_first_reg   <= cmd.first;
        prod_first_reg <= rd_first_reg;
        prod_reg       <= a_rd_reg * b_rd_reg;
        if (prod_vld_reg) begin
            acc_reg <= acc_next;
        end
    end

    always_comb begin
        if (prod_first_reg) begin
            acc_next = SUM_W'(prod_reg);
        end else begin
            acc_next = acc_reg + SUM_W'(prod_reg);
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_row_reg  <= cmd.out_row;
            out_col_reg  <= cmd.out_col;
            out_sum_reg  <= acc_reg;
            out_last_reg <= cmd.out_last;
        end
    end

    assign status.pipe_busy = rd_vld_reg || prod_vld_reg;
    assign status.out_free  = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - SUM_W - 2*IDX_W){1'b0}},
                       out_sum_reg, out_col_reg, out_row_reg};

endmodule

`default_nettype wire

@@ src/matrix_multiply_engine_core.sv @@
// Top level of the matrix multiply engine: joins the controller and the
// datapath. Depends on mme_pkg, mme_ctrl and mme_dp.
//
//   Channel   Direction  Handshake          Content
//   s_*       in         s_tvalid/s_tready  opcode in tuser, row/col/value in tdata
//   m_*       out        m_tvalid/m_tready  out_row/out_col/sum in tdata, last in tlast
//   cfg_*     in         cfg_we             register index and write data
//
// A compute transaction emits M*N results; for each, the sequencer issues K pairs
// of store reads, then waits for the pipeline to drain and for the result register
// to be free before handing it the sum. Reset is synchronous, active low, clears
// control state and sets all three dimension registers to eight; the stores are
// not cleared. A stalled result channel holds the sequencer waiting; no input is
// taken while a compute runs.
`default_nettype none

module matrix_multiply_engine_core
    import mme_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Configuration write port.
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [DIM_W-1:0]      cfg_wdata,

    // Input stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // row[2:0], col[5:3], value[21:6], zero fill
    input  wire logic [OP_W-1:0]       s_tuser,   // opcode[1:0]

    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // out_row[2:0], out_col[5:3], sum[40:6], zero fill
    output logic                       m_tlast    // last element of the result matrix
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller decodes each input transaction and walks the i, j and
    // l loops, issuing one pair of store reads per cycle during a dot product.
    mme_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds both stores, the registered multiplier and the
    // accumulator, and the output register that decouples the result stream.
    mme_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
